[rtl/smkbu_pkg.sv]
// Shared constants, types and helpers for the keyed byte unmask unit.
// No dependencies; imported by smkbu_mul64 and the top level.
package smkbu_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam logic [7:0]  KEY_TWEAK    = 8'hAA;

    // Byte offsets of the second and third mask taps relative to the first
    localparam logic [2:0]  TAP2_OFS     = 3'd3;
    localparam logic [2:0]  TAP3_OFS     = 3'd7;

    localparam int unsigned NUM_STAGES   = 7;

    // Load enables for the two register stages of one multiplier
    typedef struct packed {
        logic pp;
        logic sum;
    } t_mul_en;

    function automatic logic [7:0] byte_at(input logic [63:0] z, input logic [2:0] idx);
        byte_at = z[{idx, 3'b000} +: 8];
    endfunction

endpackage

[rtl/smkbu_mul64.sv]
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Depends on smkbu_pkg (t_mul_en).
module smkbu_mul64
    import smkbu_pkg::*;
(
    input  logic        i_clk,
    input  t_mul_en     i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_z
);

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_z;

    logic [63:0] n_ll;
    logic [63:0] n_lh_full;
    logic [63:0] n_hl_full;
    logic [31:0] n_cross;
    logic [63:0] n_z;

    // Three 32x32 partial products; the high-by-high term falls outside 64 bits
    always_comb begin
        n_ll      = i_a[31:0]  * i_b[31:0];
        n_lh_full = i_a[31:0]  * i_b[63:32];
        n_hl_full = i_a[63:32] * i_b[31:0];
    end

    always_comb begin
        n_cross = r_lh + r_hl;
        n_z     = r_ll + {n_cross, 32'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.pp) begin
            r_ll <= n_ll;
            r_lh <= n_lh_full[31:0];
            r_hl <= n_hl_full[31:0];
        end
        if (i_en.sum) begin
            r_z <= n_z;
        end
    end

    assign o_z = r_z;

endmodule

[rtl/splitmix_keyed_byte_unmask_unit.sv]
// Keyed byte unmask unit: splitmix64 keystream per byte position, top level.
// Depends on smkbu_pkg and smkbu_mul64.

// Each transfer carries a byte and its position. One item can enter every
// cycle while the output side takes results without stalling. The pipeline
// holds three 64-bit multiplies (position times gamma and the two finalizer
// rounds), each split into a partial-product stage and a summing stage, plus
// one output stage that forms the mask. Stages advance independently, so a
// stalled output still lets new items fill empty stages. The key register is
// to be written by the user only while idle; the block does not enforce it.
module splitmix_keyed_byte_unmask_unit
    import smkbu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_position,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte
);

    localparam int unsigned LAST = NUM_STAGES - 1;

    logic [63:0]           r_key;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] adv;
    logic [2:0]            r_sel  [LAST];
    logic [7:0]            r_byte [LAST];
    logic [7:0]            r_out;

    logic [7:0]  n_byte;
    logic [63:0] gamma_z;
    logic [63:0] mix_a_z;
    logic [63:0] mix_b_z;
    logic [63:0] z1;
    logic [63:0] z2;
    logic [63:0] z3;
    logic [7:0]  mask;
    logic [7:0]  n_out;
    t_mul_en     en_gamma;
    t_mul_en     en_mix_a;
    t_mul_en     en_mix_b;

    // Stage k may load when it is empty or its content moves on
    always_comb begin
        adv[LAST] = !r_vld[LAST] || i_out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[LAST];
    assign o_out_byte  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Key-byte arithmetic needs nothing from the mixer; do it on entry
    assign n_byte = i_data_byte + r_key[15:8] - (r_key[7:0] ^ KEY_TWEAK);

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_sel[0]  <= i_position[2:0];
            r_byte[0] <= n_byte;
        end
        for (int k = 1; k < LAST; k++) begin
            if (adv[k]) begin
                r_sel[k]  <= r_sel[k-1];
                r_byte[k] <= r_byte[k-1];
            end
        end
    end

    assign en_gamma = '{pp: adv[0], sum: adv[1]};
    assign en_mix_a = '{pp: adv[2], sum: adv[3]};
    assign en_mix_b = '{pp: adv[4], sum: adv[5]};

    smkbu_mul64 u_mul_gamma (
        .i_clk (i_clk),
        .i_en  (en_gamma),
        .i_a   ({32'b0, i_position}),
        .i_b   (GOLDEN_GAMMA),
        .o_z   (gamma_z)
    );

    assign z1 = (r_key ^ gamma_z) ^ ((r_key ^ gamma_z) >> 30);

    smkbu_mul64 u_mul_mix_a (
        .i_clk (i_clk),
        .i_en  (en_mix_a),
        .i_a   (z1),
        .i_b   (MIX_MUL_A),
        .o_z   (mix_a_z)
    );

    assign z2 = mix_a_z ^ (mix_a_z >> 27);

    smkbu_mul64 u_mul_mix_b (
        .i_clk (i_clk),
        .i_en  (en_mix_b),
        .i_a   (z2),
        .i_b   (MIX_MUL_B),
        .o_z   (mix_b_z)
    );

    assign z3 = mix_b_z ^ (mix_b_z >> 31);

    // Three byte taps of the finalized word, offsets wrap within the word
    always_comb begin
        mask  = byte_at(z3, r_sel[LAST-1])
              ^ byte_at(z3, r_sel[LAST-1] + TAP2_OFS)
              ^ byte_at(z3, r_sel[LAST-1] + TAP3_OFS);
        n_out = r_byte[LAST-1] ^ mask;
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST]) begin
            r_out <= n_out;
        end
    end

    // An empty output stage frees the whole chain back to the input
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAST] |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // A result held by the output side keeps its value
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("stalled result lost or changed");

    // The first stage fills only from an input transfer
    a_fill_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vld[0]) |-> $past(i_in_valid && o_in_ready))
        else $error("first stage filled without input transfer");

    // A full stage that cannot advance keeps its item
    a_no_drop_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !adv[4]) |=> r_vld[3])
        else $error("pipeline item dropped under stall");

endmodule
